>>> rtl/pdfls_pkg.sv
// ----------------------------------------------------------------------------
// pdfls_pkg
// Shared types, character codes and the byte mapping function for the
// literal string decoder.
// ----------------------------------------------------------------------------
package pdfls_pkg;

	localparam int unsigned DEF_MAX_NESTING = 255;
	localparam int unsigned RES_FIFO_DEPTH  = 4;

	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_QMARK   = 8'h3F;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_LOWER_B = 8'h62;
	localparam logic [7:0] CH_LOWER_F = 8'h66;
	localparam logic [7:0] CH_LOWER_N = 8'h6E;
	localparam logic [7:0] CH_LOWER_R = 8'h72;
	localparam logic [7:0] CH_LOWER_T = 8'h74;
	localparam logic [7:0] PRINT_LO   = 8'h20;
	localparam logic [7:0] PRINT_HI   = 8'h7E;

	localparam logic [1:0] OCT_LAST_COUNT = 2'd2;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_STR,
		MODE_ESC,
		MODE_CR,
		MODE_OCT
	} pdfls_mode_t;

	typedef struct packed {
		logic [6:0] ch;
		logic       char_valid;
		logic       done;
		logic       trunc;
	} pdfls_res_t;

	// results of one byte: count is 0, 1 or 2; r0 goes out first
	typedef struct packed {
		logic [1:0] count;
		pdfls_res_t r1;
		pdfls_res_t r0;
	} pdfls_step_t;

	function automatic logic [6:0] map_byte(input logic [7:0] b);
		logic [6:0] r;
		if (b >= PRINT_LO && b <= PRINT_HI) begin
			r = b[6:0];
		end else if (b == CH_LF || b == CH_CR) begin
			r = CH_LF[6:0];
		end else begin
			r = CH_QMARK[6:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/pdfls_core.sv
// ----------------------------------------------------------------------------
// pdfls_core
// Decoder state (mode, nesting depth, octal accumulator) and the per-byte
// next-state and result logic. One byte is taken per enabled cycle.
// ----------------------------------------------------------------------------
module pdfls_core import pdfls_pkg::*; #(
	parameter int unsigned MAX_NESTING = DEF_MAX_NESTING
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step_en,
	input  logic [7:0]  byte_in,
	input  logic        eod,
	output pdfls_step_t step
);

	localparam int unsigned DEPTH_W = $clog2(MAX_NESTING + 1);
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_NESTING);

	pdfls_mode_t        mode_q, mode_d;
	logic [DEPTH_W-1:0] depth_q, depth_d;
	logic [7:0]         oval_q, oval_d;
	logic [1:0]         ocnt_q, ocnt_d;

	// plain string context
	logic               p_emit, p_close, p_esc;
	logic [6:0]         p_ch;
	logic [DEPTH_W-1:0] p_depth;

	logic               is_digit;
	logic [7:0]         oct_sum;
	logic               closed, fin;
	logic [1:0]         n;
	pdfls_res_t         r0, r1;

	assign is_digit = (byte_in >= CH_DIGIT_0) && (byte_in <= CH_DIGIT_9);
	assign oct_sum  = {oval_q[4:0], 3'b000} + {4'b0000, byte_in[3:0]};

	always_comb begin
		p_emit  = 1'b0;
		p_close = 1'b0;
		p_esc   = 1'b0;
		p_ch    = map_byte(byte_in);
		p_depth = depth_q;
		case (byte_in)
			CH_BSLASH: begin
				p_esc = 1'b1;
			end
			CH_LPAREN: begin
				p_emit = 1'b1;
				if (depth_q < DEPTH_MAX) begin
					p_depth = depth_q + 1'b1;
				end
			end
			CH_RPAREN: begin
				if (depth_q == '0) begin
					p_close = 1'b1;
				end else begin
					p_emit  = 1'b1;
					p_depth = depth_q - 1'b1;
				end
			end
			default: begin
				p_emit = 1'b1;
			end
		endcase
	end

	always_comb begin
		mode_d  = mode_q;
		depth_d = depth_q;
		oval_d  = oval_q;
		ocnt_d  = ocnt_q;
		closed  = 1'b0;
		n       = 2'd0;
		r0      = '0;
		r1      = '0;
		case (mode_q)
			MODE_IDLE: begin
				if (byte_in == CH_LPAREN) begin
					mode_d  = MODE_STR;
					depth_d = '0;
					oval_d  = '0;
					ocnt_d  = '0;
				end
			end
			MODE_STR, MODE_CR: begin
				mode_d = MODE_STR;
				if (mode_q == MODE_STR || byte_in != CH_LF) begin
					depth_d = p_depth;
					closed  = p_close;
					if (p_esc) begin
						mode_d = MODE_ESC;
					end
					if (p_emit) begin
						r0 = '{ch: p_ch, char_valid: 1'b1, done: 1'b0, trunc: 1'b0};
						n  = 2'd1;
					end
				end
			end
			MODE_ESC: begin
				mode_d = MODE_STR;
				case (byte_in) inside
					CH_LOWER_N, CH_LOWER_R: begin
						r0 = '{ch: CH_LF[6:0], char_valid: 1'b1, done: 1'b0, trunc: 1'b0};
						n  = 2'd1;
					end
					CH_LOWER_T: begin
						r0 = '{ch: CH_SPACE[6:0], char_valid: 1'b1, done: 1'b0, trunc: 1'b0};
						n  = 2'd1;
					end
					CH_LOWER_B, CH_LOWER_F, CH_LF: begin
					end
					CH_CR: begin
						mode_d = MODE_CR;
					end
					[CH_DIGIT_0:CH_DIGIT_9]: begin
						oval_d = {4'b0000, byte_in[3:0]};
						ocnt_d = 2'd1;
						mode_d = MODE_OCT;
					end
					default: begin
						r0 = '{ch: map_byte(byte_in), char_valid: 1'b1, done: 1'b0, trunc: 1'b0};
						n  = 2'd1;
					end
				endcase
			end
			MODE_OCT: begin
				if (is_digit) begin
					if (ocnt_q == OCT_LAST_COUNT) begin
						r0 = '{ch: map_byte(oct_sum), char_valid: 1'b1, done: 1'b0,
							trunc: 1'b0};
						n      = 2'd1;
						oval_d = '0;
						ocnt_d = '0;
						mode_d = MODE_STR;
					end else begin
						oval_d = oct_sum;
						ocnt_d = ocnt_q + 1'b1;
					end
				end else begin
					// octal character first, then whatever the terminating byte gives
					r0 = '{ch: map_byte(oval_q), char_valid: 1'b1, done: 1'b0, trunc: 1'b0};
					n       = 2'd1;
					oval_d  = '0;
					ocnt_d  = '0;
					mode_d  = p_esc ? MODE_ESC : MODE_STR;
					depth_d = p_depth;
					closed  = p_close;
					if (p_emit) begin
						r1 = '{ch: p_ch, char_valid: 1'b1, done: 1'b0, trunc: 1'b0};
						n  = 2'd2;
					end
				end
			end
			default: begin
				mode_d  = MODE_IDLE;
				depth_d = '0;
				oval_d  = '0;
				ocnt_d  = '0;
			end
		endcase

		fin = closed || (eod && mode_d != MODE_IDLE);
		if (fin) begin
			// flush a pending octal value at end of data
			if (!closed && mode_d == MODE_OCT) begin
				r0 = '{ch: map_byte(oval_d), char_valid: 1'b1, done: 1'b0, trunc: 1'b0};
				n  = 2'd1;
			end
			if (n == 2'd0) begin
				n = 2'd1;
			end
			if (n == 2'd2) begin
				r1.done  = 1'b1;
				r1.trunc = !closed;
			end else begin
				r0.done  = 1'b1;
				r0.trunc = !closed;
			end
			mode_d  = MODE_IDLE;
			depth_d = '0;
			oval_d  = '0;
			ocnt_d  = '0;
		end

		step = '{count: n, r1: r1, r0: r0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			depth_q <= '0;
			oval_q  <= '0;
			ocnt_q  <= '0;
		end else if (step_en) begin
			mode_q  <= mode_d;
			depth_q <= depth_d;
			oval_q  <= oval_d;
			ocnt_q  <= ocnt_d;
		end
	end

endmodule

>>> rtl/pdf_literal_string_decoder.sv
// A byte transferred on the slave side is held in the staging register, then
// decoded into the result queue; its first result is offered on the master side from there.
// Throughput: one byte per cycle while the queue has room for two results; a
// byte that yields two results is absorbed by a four-entry result queue.
// Reset: arst_n clears the decoder state to idle and empties the queue.
// ----------------------------------------------------------------------------
// pdf_literal_string_decoder
// Decodes PDF literal strings from a byte stream into printable characters,
// with nesting, escapes and octal codes handled.
// ----------------------------------------------------------------------------
module pdf_literal_string_decoder import pdfls_pkg::*; #(
	parameter int unsigned MAX_NESTING = DEF_MAX_NESTING
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,   // end_of_data
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
	output logic [1:0] m_tuser,   // [0] char_valid, [1] truncated
	output logic       m_tlast    // string_done
);

	localparam int unsigned PTR_W = $clog2(RES_FIFO_DEPTH);
	localparam int unsigned CNT_W = $clog2(RES_FIFO_DEPTH + 1);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eod_s1;
	logic        consume;
	logic        pop;
	pdfls_step_t step;

	pdfls_res_t       fifo_q [RES_FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PTR_W-1:0] wr_next;

	// take the staged byte only when the queue has room for two results
	assign consume  = valid_s1 && (cnt_q <= CNT_W'(RES_FIFO_DEPTH - 2));
	assign s_tready = !valid_s1 || consume;
	assign pop      = m_tvalid && m_tready;
	assign wr_next  = wr_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eod_s1  <= s_tlast;
		end
	end

	pdfls_core #(
		.MAX_NESTING(MAX_NESTING)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (consume),
		.byte_in (byte_s1),
		.eod     (eod_s1),
		.step    (step)
	);

	always_ff @(posedge clk) begin
		if (consume && step.count != 2'd0) begin
			fifo_q[wr_q] <= step.r0;
		end
		if (consume && step.count == 2'd2) begin
			fifo_q[wr_next] <= step.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (consume) begin
				wr_q <= wr_q + PTR_W'(step.count);
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (consume ? CNT_W'(step.count) : '0) - CNT_W'(pop);
		end
	end

	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = {1'b0, fifo_q[rd_q].ch};
	assign m_tuser  = {fifo_q[rd_q].trunc, fifo_q[rd_q].char_valid};
	assign m_tlast  = fifo_q[rd_q].done;

endmodule

>>> bench/tb_pdf_literal_string_decoder.sv
// ----------------------------------------------------------------------------
// tb_pdf_literal_string_decoder
// Self-checking bench for the literal string decoder. A byte queue feeds the
// slave side with random gaps, and a behavioral decoder predicts each result.
// The master side stalls at random and every transfer is compared field by
// field. Stimulus covers directed corner strings, a saturating nest and
// random strings built from escapes, octal codes and raw bytes.
// ----------------------------------------------------------------------------
module tb_pdf_literal_string_decoder import pdfls_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [7:0] data;
		logic       eod;
		logic       drain;
	} byte_item_t;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;   // [7:0] in_byte
	logic       s_tlast  = 1'b0;    // end_of_data
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;            // [6:0] out_char, [7] zero
	logic [1:0] m_tuser;            // [0] char_valid, [1] truncated
	logic       m_tlast;            // string_done

	// behavioral decoder state
	pdfls_mode_t dec_mode    = MODE_IDLE;
	int unsigned dec_depth   = 0;
	logic [7:0]  dec_oct     = 8'h00;
	logic [1:0]  dec_oct_cnt = 2'd0;
	pdfls_res_t  step_res[2];
	int          step_n;

	byte_item_t  byte_q[$];
	pdfls_res_t  decoded_q[$];
	logic        drain_next = 1'b0;

	int fail_cnt       = 0;
	int results_seen   = 0;
	int bytes_sent     = 0;
	int strings_closed = 0;
	int strings_cut    = 0;
	int depth_peak     = 0;
	int src_gap        = 0;
	int snk_gap        = 0;
	bit src_calm       = 1'b0;
	bit snk_calm       = 1'b1;

	pdf_literal_string_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #4 clk = ~clk;

	function automatic logic [6:0] printable(input logic [7:0] b);
		return (b >= PRINT_LO && b <= PRINT_HI) ? b[6:0] :
			(b == CH_CR || b == CH_LF) ? CH_LF[6:0] : CH_QMARK[6:0];
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		return $urandom_range(8, 24);
	endfunction

	function automatic logic [7:0] rand_digit();
		return CH_DIGIT_0 + 8'($urandom_range(0, 9));
	endfunction

	task automatic add_char(input logic [6:0] ch);
		step_res[step_n] = '{ch: ch, char_valid: 1'b1, done: 1'b0, trunc: 1'b0};
		step_n++;
	endtask

	task automatic clear_state();
		dec_mode    = MODE_IDLE;
		dec_depth   = 0;
		dec_oct     = 8'h00;
		dec_oct_cnt = 2'd0;
	endtask

	task automatic plain_byte(input logic [7:0] c, output logic closed);
		closed = 1'b0;
		if (c == CH_BSLASH) begin
			dec_mode = MODE_ESC;
		end else if (c == CH_LPAREN) begin
			// saturate depth, still pass the paren through
			if (dec_depth < DEF_MAX_NESTING) dec_depth++;
			if (dec_depth > depth_peak) depth_peak = dec_depth;
			add_char(CH_LPAREN[6:0]);
		end else if (c == CH_RPAREN) begin
			if (dec_depth == 0) begin
				closed = 1'b1;
			end else begin
				dec_depth--;
				add_char(CH_RPAREN[6:0]);
			end
		end else begin
			add_char(printable(c));
		end
	endtask

	// advance the decoder by one byte and queue what it should produce
	task automatic decode_byte(input logic [7:0] c, input logic eod);
		logic closed;
		logic is_digit;
		closed   = 1'b0;
		step_n   = 0;
		is_digit = (c >= CH_DIGIT_0 && c <= CH_DIGIT_9);
		case (dec_mode)
		MODE_IDLE: begin
			if (c == CH_LPAREN) begin
				clear_state();
				dec_mode = MODE_STR;
			end
		end
		MODE_STR: plain_byte(c, closed);
		MODE_ESC: begin
			dec_mode = MODE_STR;
			if (c == CH_LOWER_N || c == CH_LOWER_R) begin
				add_char(CH_LF[6:0]);
			end else if (c == CH_LOWER_T) begin
				add_char(CH_SPACE[6:0]);
			end else if (c == CH_LOWER_B || c == CH_LOWER_F || c == CH_LF) begin
				// drop
			end else if (c == CH_CR) begin
				dec_mode = MODE_CR;
			end else if (is_digit) begin
				dec_oct     = c - CH_DIGIT_0;
				dec_oct_cnt = 2'd1;
				dec_mode    = MODE_OCT;
			end else begin
				add_char(printable(c));
			end
		end
		MODE_CR: begin
			// swallow LF after an escaped CR
			dec_mode = MODE_STR;
			if (c != CH_LF) plain_byte(c, closed);
		end
		MODE_OCT: begin
			if (is_digit) begin
				dec_oct = {dec_oct[4:0], 3'b000} + (c - CH_DIGIT_0);
				if (dec_oct_cnt == OCT_LAST_COUNT) begin
					add_char(printable(dec_oct));
					dec_oct     = 8'h00;
					dec_oct_cnt = 2'd0;
					dec_mode    = MODE_STR;
				end else begin
					dec_oct_cnt++;
				end
			end else begin
				add_char(printable(dec_oct));
				dec_oct     = 8'h00;
				dec_oct_cnt = 2'd0;
				dec_mode    = MODE_STR;
				plain_byte(c, closed);
			end
		end
		default: clear_state();
		endcase

		if (closed || (eod && dec_mode != MODE_IDLE)) begin
			if (!closed && dec_mode == MODE_OCT) add_char(printable(dec_oct));
			if (step_n == 0) begin
				step_res[0] = '0;
				step_n      = 1;
			end
			step_res[step_n-1].done  = 1'b1;
			step_res[step_n-1].trunc = !closed;
			if (closed) strings_closed++;
			else strings_cut++;
			clear_state();
		end
		for (int i = 0; i < step_n; i++) decoded_q = {decoded_q, step_res[i]};
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		fail_cnt++;
		if (fail_cnt <= 20)
			$display("mismatch at result %0d: %s got %0h want %0h",
				results_seen, what, got, want);
	endtask

	task automatic check_result();
		pdfls_res_t want;
		results_seen++;
		if (decoded_q.size() == 0) begin
			report_mismatch("result with nothing pending, tdata", m_tdata, 0);
		end else begin
			want = decoded_q.pop_front();
			if (m_tdata[6:0] != want.ch) report_mismatch("out_char", m_tdata[6:0], want.ch);
			if (m_tdata[7] != 1'b0) report_mismatch("tdata pad bit", m_tdata[7], 0);
			if (m_tuser[0] != want.char_valid)
				report_mismatch("char_valid", m_tuser[0], want.char_valid);
			if (m_tlast != want.done) report_mismatch("string_done", m_tlast, want.done);
			if (m_tuser[1] != want.trunc) report_mismatch("truncated", m_tuser[1], want.trunc);
		end
	endtask

	task automatic put(input logic [7:0] data, input logic eod);
		byte_item_t it;
		it         = '{data: data, eod: eod, drain: drain_next};
		byte_q     = {byte_q, it};
		drain_next = 1'b0;
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++) put(s[i], 1'b0);
	endtask

	// one string with random content, mostly well formed, sometimes cut off
	task automatic gen_string();
		logic [7:0] body[$];
		string      esc_set;
		int         depth_open;
		int         junk;
		bit         cut;
		esc_set    = "nrtbf\\()";
		depth_open = 0;
		junk       = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
		repeat (junk) put(8'($urandom), $urandom_range(0, 7) == 0);
		body = {body, CH_LPAREN};
		repeat ($urandom_range(0, 10)) begin
			case ($urandom_range(0, 11))
			0, 1, 2, 3: body = {body, 8'($urandom_range(PRINT_LO, PRINT_HI))};
			4: begin
				body = {body, CH_LPAREN};
				depth_open++;
			end
			5: begin
				if (depth_open > 0) begin
					body = {body, CH_RPAREN};
					depth_open--;
				end
			end
			6: begin
				body = {body, CH_BSLASH};
				if ($urandom_range(0, 3) == 0) body = {body, 8'($urandom)};
				else body = {body, 8'(esc_set[$urandom_range(0, esc_set.len() - 1)])};
			end
			7: begin
				// line continuation forms
				body = {body, CH_BSLASH};
				case ($urandom_range(0, 2))
				0: begin
					body = {body, CH_CR};
					body = {body, CH_LF};
				end
				1: begin
					body = {body, CH_CR};
					body = {body, 8'($urandom)};
				end
				default: body = {body, CH_LF};
				endcase
			end
			8, 9: begin
				body = {body, CH_BSLASH};
				repeat ($urandom_range(1, 4)) body = {body, rand_digit()};
			end
			default: body = {body, 8'($urandom)};
			endcase
		end
		cut = ($urandom_range(0, 3) == 0);
		if (cut) begin
			case ($urandom_range(0, 3))
			1: body = {body, CH_BSLASH};
			2: begin
				body = {body, CH_BSLASH};
				body = {body, rand_digit()};
			end
			3: begin
				body = {body, CH_BSLASH};
				body = {body, CH_CR};
			end
			default: begin end
			endcase
		end else begin
			repeat (depth_open + 1) body = {body, CH_RPAREN};
		end
		foreach (body[i]) put(body[i], cut && i == body.size() - 1);
	endtask

	// slave side driver
	always @(posedge clk) begin
		byte_item_t nxt;
		logic       load;
		load = 1'b0;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				decode_byte(s_tdata, s_tlast);
				bytes_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap--;
				end else if (byte_q.size() != 0 &&
						!(byte_q[0].drain && decoded_q.size() != 0)) begin
					nxt  = byte_q.pop_front();
					load = 1'b1;
					if ($urandom_range(0, 99) == 0) src_calm = !src_calm;
					src_gap = src_calm ? 0 : pick_gap();
				end
				s_tvalid <= load;
				if (load) begin
					s_tdata <= nxt.data;
					s_tlast <= nxt.eod;
				end
			end
		end
	end

	// master side monitor with random stalls
	always @(posedge clk) begin
		logic rdy;
		if (arst_n) begin
			if (m_tvalid && m_tready) check_result();
			if (snk_gap > 0) begin
				snk_gap--;
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
				if ($urandom_range(0, 149) == 0) snk_calm = !snk_calm;
				if (!snk_calm && $urandom_range(0, 3) == 0) snk_gap = pick_gap();
			end
			m_tready <= rdy;
		end
	end

	initial begin
		int base;
		// idle noise and end of data while idle
		put_text("x");
		put(8'hFF, 1'b1);
		// opening paren as the last byte
		put(CH_LPAREN, 1'b1);
		// extremes, simple escapes, escaped CR with and without LF
		put(CH_LPAREN, 1'b0);
		put(8'h00, 1'b0);
		put(8'hFF, 1'b0);
		put_text("\\n\\t\\b\\");
		put(CH_CR, 1'b0);
		put(CH_LF, 1'b0);
		put(CH_BSLASH, 1'b0);
		put(CH_CR, 1'b0);
		put(CH_RPAREN, 1'b0);
		// octal ended by a letter, 9s as digits, octal flushed at end of data
		put_text("(\\41X\\999\\");
		put(rand_digit(), 1'b1);
		// backslash as the last byte
		put_text("(a");
		put(CH_BSLASH, 1'b1);

		// push depth past saturation, then unwind and close
		drain_next = 1'b1;
		put(CH_LPAREN, 1'b0);
		repeat (DEF_MAX_NESTING + 2) put(CH_LPAREN, 1'b0);
		repeat (DEF_MAX_NESTING + 1) put(CH_RPAREN, 1'b0);

		drain_next = 1'b1;
		base = byte_q.size();
		while (byte_q.size() < base + 650) gen_string();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_q.size() != 0 || s_tvalid) @(posedge clk);
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (decoded_q.size() != 0)
			report_mismatch("results never delivered", 0, decoded_q.size());

		$display("sent %0d bytes, checked %0d results", bytes_sent, results_seen);
		$display("%0d strings closed, %0d cut by end of data, nesting reached %0d",
			strings_closed, strings_cut, depth_peak);
		if (fail_cnt == 0) begin
			$display("tb_pdf_literal_string_decoder OK");
		end else begin
			$display("tb_pdf_literal_string_decoder NOT OK");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d results still pending", decoded_q.size());
		$display("tb_pdf_literal_string_decoder NOT OK");
		$finish;
	end

endmodule
